/* design/sbus_frame_receiver_defines.svh */
// ----------------------------------------------------------------------------
// SBUS frame receiver assertion macros
// Concurrent assertion wrappers for the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DEFINES_SVH

// checked property, disabled while reset is high
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also checked during reset
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sbus_frx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frx_pkg
// Types and constants shared by the SBUS frame receiver modules.
// ----------------------------------------------------------------------------
package sbus_frx_pkg;

   localparam int INDEX_W       = 5;
   localparam int PAYLOAD_BYTES = 22;
   localparam int NUM_CH        = 16;
   localparam int CH_W          = 11;
   localparam int CH_IDX_W      = 4;
   localparam int FRAME_BITS    = PAYLOAD_BYTES * 8;

   localparam logic [7:0]          START_BYTE  = 8'h0F;
   localparam logic [INDEX_W-1:0]  PAYLOAD_LEN = INDEX_W'(PAYLOAD_BYTES);
   localparam logic [INDEX_W-1:0]  FRAME_LIMIT = INDEX_W'(25);
   localparam logic [CH_IDX_W-1:0] LAST_CH     = CH_IDX_W'(NUM_CH - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_CHANNEL     = 2'd0,
      ST_END_MISSING = 2'd1,
      ST_OVERFLOW    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_STORE    = 2'd0,
      CMD_DECODE   = 2'd1,
      CMD_END_ERR  = 2'd2,
      CMD_OVERFLOW = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [INDEX_W-1:0] idx;
      logic [7:0]         data;
   } cmd_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      cmd_type head;
   } queue_status_type;

endpackage

/* design/sbus_frx_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frx_queue
// Short command queue between the byte classifier and the frame engine.
// ----------------------------------------------------------------------------
module sbus_frx_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   input  wire sbus_frx_pkg::cmd_type     push_cmd,
   input  wire                            pop,
   output sbus_frx_pkg::queue_status_type status
);

   sbus_frx_pkg::cmd_type entry_ff [sbus_frx_pkg::QUEUE_DEPTH];

   logic [sbus_frx_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sbus_frx_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sbus_frx_pkg::QCNT_W-1:0] count_ff, count_in;

   function automatic logic [sbus_frx_pkg::QPTR_W-1:0] next_ptr(
      input logic [sbus_frx_pkg::QPTR_W-1:0] p
   );
      logic [sbus_frx_pkg::QPTR_W-1:0] r;
      if (p == sbus_frx_pkg::QPTR_W'(sbus_frx_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + sbus_frx_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + sbus_frx_pkg::QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - sbus_frx_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign status = '{
      empty: (count_ff == '0),
      full:  (count_ff == sbus_frx_pkg::QCNT_W'(sbus_frx_pkg::QUEUE_DEPTH)),
      head:  entry_ff[rd_ptr_ff]
   };

endmodule
`default_nettype wire

/* design/sbus_frx_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frx_front
// Tracks the write index and end-marker state and turns payload bytes, frame
// ends and errors into commands for the frame engine.
// ----------------------------------------------------------------------------
module sbus_frx_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        accept,
   input  wire [7:0]                  rx_byte,
   output logic                       push,
   output sbus_frx_pkg::cmd_type      push_cmd
);

   logic [sbus_frx_pkg::INDEX_W-1:0] write_index_ff, write_index_in;
   logic                             await_end_ff, await_end_in;

   always_comb begin
      write_index_in = write_index_ff;
      await_end_in   = await_end_ff;
      push           = 1'b0;
      push_cmd.op    = sbus_frx_pkg::CMD_STORE;
      push_cmd.idx   = write_index_ff;
      push_cmd.data  = rx_byte;
      if (accept) begin
         if (await_end_ff) begin
            // any byte here is the second end marker, 0x0F included
            await_end_in = 1'b0;
            if (rx_byte != 8'h00) begin
               push        = 1'b1;
               push_cmd.op = sbus_frx_pkg::CMD_END_ERR;
            end else if (write_index_ff == sbus_frx_pkg::PAYLOAD_LEN) begin
               push        = 1'b1;
               push_cmd.op = sbus_frx_pkg::CMD_DECODE;
            end
         end else if (rx_byte == sbus_frx_pkg::START_BYTE) begin
            write_index_in = '0;
         end else if (write_index_ff < sbus_frx_pkg::FRAME_LIMIT) begin
            if (rx_byte == 8'h00) begin
               await_end_in = 1'b1;
            end else begin
               // bytes past the payload only advance the index
               push           = (write_index_ff < sbus_frx_pkg::PAYLOAD_LEN);
               write_index_in = write_index_ff + sbus_frx_pkg::INDEX_W'(1);
            end
         end else begin
            push        = 1'b1;
            push_cmd.op = sbus_frx_pkg::CMD_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         await_end_ff   <= 1'b0;
      end else begin
         write_index_ff <= write_index_in;
         await_end_ff   <= await_end_in;
      end
   end

endmodule
`default_nettype wire

/* design/sbus_frx_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sbus_frame_receiver_defines.svh"
// ----------------------------------------------------------------------------
// sbus_frx_back
// Frame engine: stores payload bytes, unpacks the sixteen channels one per
// cycle unless stalled, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module sbus_frx_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire sbus_frx_pkg::queue_status_type   q_status,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [sbus_frx_pkg::CH_IDX_W-1:0]     rsp_channel_index,
   output logic [sbus_frx_pkg::CH_W-1:0]         rsp_channel_value,
   output logic                                  rsp_last
);

   logic [7:0] frame_bytes_ff [sbus_frx_pkg::PAYLOAD_BYTES];

   logic [sbus_frx_pkg::FRAME_BITS-1:0] shreg_ff, shreg_in;
   logic                                dec_active_ff, dec_active_in;
   logic [sbus_frx_pkg::CH_IDX_W-1:0]   ch_cnt_ff, ch_cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   sbus_frx_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [sbus_frx_pkg::CH_IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [sbus_frx_pkg::CH_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic out_free, emit, pop_err, pop_store, pop_decode, load_rsp;
   logic chan_last_beat, idx_is_last, last_emit;
   sbus_frx_pkg::cmd_type head;

   assign head     = q_status.head;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop = 1'b0;
      if (!q_status.empty && !dec_active_ff) begin
         case (head.op)
            sbus_frx_pkg::CMD_STORE,
            sbus_frx_pkg::CMD_DECODE:   pop = 1'b1;
            sbus_frx_pkg::CMD_END_ERR,
            sbus_frx_pkg::CMD_OVERFLOW: pop = out_free;
            default:                    pop = 1'b0;
         endcase
      end
   end

   assign pop_store  = pop && (head.op == sbus_frx_pkg::CMD_STORE);
   assign pop_decode = pop && (head.op == sbus_frx_pkg::CMD_DECODE);
   assign pop_err    = pop && ((head.op == sbus_frx_pkg::CMD_END_ERR) ||
                               (head.op == sbus_frx_pkg::CMD_OVERFLOW));
   assign emit       = dec_active_ff && out_free;
   assign load_rsp   = emit || pop_err;

   always_comb begin
      shreg_in      = shreg_ff;
      dec_active_in = dec_active_ff;
      ch_cnt_in     = ch_cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = out_free ? load_rsp : rsp_valid_ff;
      if (pop_decode) begin
         dec_active_in = 1'b1;
         ch_cnt_in     = '0;
      end else if (emit) begin
         shreg_in      = shreg_ff >> sbus_frx_pkg::CH_W;
         ch_cnt_in     = ch_cnt_ff + sbus_frx_pkg::CH_IDX_W'(1);
         dec_active_in = (ch_cnt_ff != sbus_frx_pkg::LAST_CH);
         rsp_status_in = sbus_frx_pkg::ST_CHANNEL;
         rsp_index_in  = ch_cnt_ff;
         rsp_value_in  = shreg_ff[sbus_frx_pkg::CH_W-1:0];
         rsp_last_in   = (ch_cnt_ff == sbus_frx_pkg::LAST_CH);
      end else if (pop_err) begin
         rsp_status_in = (head.op == sbus_frx_pkg::CMD_END_ERR) ?
                         sbus_frx_pkg::ST_END_MISSING : sbus_frx_pkg::ST_OVERFLOW;
         rsp_index_in  = '0;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_active_ff <= 1'b0;
         ch_cnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dec_active_ff <= dec_active_in;
         ch_cnt_ff     <= ch_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_decode) begin
         // byte 0 lands in the low bits: channels read little-endian
         for (int i = 0; i < sbus_frx_pkg::PAYLOAD_BYTES; i++) begin
            shreg_ff[i*8 +: 8] <= frame_bytes_ff[i];
         end
      end else begin
         shreg_ff <= shreg_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      if (pop_store) begin
         frame_bytes_ff[head.idx] <= head.data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   assign chan_last_beat = rsp_valid_ff && rsp_last_ff &&
                           (rsp_status_ff == sbus_frx_pkg::ST_CHANNEL);
   assign idx_is_last    = (rsp_index_ff == sbus_frx_pkg::LAST_CH);
   assign last_emit      = emit && (ch_cnt_ff == sbus_frx_pkg::LAST_CH);

   `SFR_ASSERT(a_no_pop_while_decoding, clock, reset, dec_active_ff |-> !pop, "pop during unpack")
   `SFR_ASSERT(a_last_channel_is_15, clock, reset, chan_last_beat |-> idx_is_last, "last off ch 15")
   `SFR_ASSERT(a_decode_ends, clock, reset, last_emit |=> !dec_active_ff, "unpack overran")

endmodule
`default_nettype wire

/* design/sbus_frame_receiver.sv */
// Error beats pass the command queue and the output register; channel beats
// also pass the unpack shifter between them. Throughput: one byte per cycle
// unless req_stall; a frame's 16 channel beats leave one per cycle unless
// rsp_stall, set by the single unpack shifter, and back up the 4-entry queue.
// Reset clears the index, end flag, queue and output valid; stored bytes stay.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// SBUS byte stream to sixteen 11-bit channel values, with end-marker and
// overflow error beats.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [7:0]                          req_rx_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [sbus_frx_pkg::CH_IDX_W-1:0]  rsp_channel_index,
   output logic [sbus_frx_pkg::CH_W-1:0]      rsp_channel_value,
   output logic                               rsp_last
);

   sbus_frx_pkg::queue_status_type q_status;
   sbus_frx_pkg::cmd_type          push_cmd;
   logic                           push, pop, accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   sbus_frx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .push     (push),
      .push_cmd (push_cmd)
   );

   sbus_frx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .status   (q_status)
   );

   sbus_frx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sbus_frame_receiver: a directed byte table, then
// random frame traffic checked against a behavioral decoder, under sender
// gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [7:0] END_MARK       = 8'h00;
   localparam logic [7:0] START          = sbus_frx_pkg::START_BYTE;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         HOLD_OFF       = 300;
   localparam int         BURST_ITEMS    = 15;
   localparam int         N_DIRECTED     = 37;

   localparam sbus_frx_pkg::status_type S_CH  = sbus_frx_pkg::ST_CHANNEL;
   localparam sbus_frx_pkg::status_type S_END = sbus_frx_pkg::ST_END_MISSING;
   localparam sbus_frx_pkg::status_type S_OVF = sbus_frx_pkg::ST_OVERFLOW;

   typedef struct packed {
      sbus_frx_pkg::status_type            status;
      logic [sbus_frx_pkg::CH_IDX_W-1:0]   chan;
      logic [sbus_frx_pkg::CH_W-1:0]       value;
      logic                                last;
   } beat_type;

   // rx byte, expected result typed in, its status
   typedef struct packed {
      logic [7:0]               rx;
      logic                     typed;
      sbus_frx_pkg::status_type status;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic [7:0]                          req_rx_byte = 8'h00;
   logic                                rsp_stall = 1'b0;
   wire                                 req_stall;
   wire                                 rsp_valid;
   wire [1:0]                           rsp_status;
   wire [sbus_frx_pkg::CH_IDX_W-1:0]    rsp_channel_index;
   wire [sbus_frx_pkg::CH_W-1:0]        rsp_channel_value;
   wire                                 rsp_last;

   // decoder state
   logic [7:0]                          frame_store [sbus_frx_pkg::PAYLOAD_BYTES];
   logic [sbus_frx_pkg::INDEX_W-1:0]    frame_index = '0;
   logic                                end_armed = 1'b0;
   beat_type                            decoded [sbus_frx_pkg::NUM_CH];

   beat_type                            channel_expect [$];
   stim_row_type                        directed_rows [N_DIRECTED];
   logic                                typed_row = 1'b0;
   sbus_frx_pkg::status_type            typed_status = S_CH;
   int                                  send_idle_pct = 8;
   int                                  recv_stall_pct = 86;
   logic                                hold_off_on = 1'b0;
   int                                  hold_off_left = HOLD_OFF;
   int                                  mismatches = 0;
   int                                  idle_cycles = 0;
   int                                  bytes_sent = 0;

   sbus_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // single error beat: index and value zero, last set
   function automatic beat_type error_beat(input sbus_frx_pkg::status_type st);
      beat_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   // Steps the decoder by one byte; fills decoded[] and returns the beat count.
   function automatic int decode_rx_byte(input logic [7:0] b);
      logic [sbus_frx_pkg::FRAME_BITS-1:0] frame_bits;
      if (end_armed) begin
         end_armed = 1'b0;
         if (b != END_MARK) begin
            decoded[0] = error_beat(S_END);
            return 1;
         end
         if (frame_index != sbus_frx_pkg::PAYLOAD_LEN)
            return 0;
         for (int i = 0; i < sbus_frx_pkg::PAYLOAD_BYTES; i++)
            frame_bits[8*i +: 8] = frame_store[i];
         for (int ch = 0; ch < sbus_frx_pkg::NUM_CH; ch++)
            decoded[ch] = {S_CH, sbus_frx_pkg::CH_IDX_W'(ch),
                           frame_bits[ch*sbus_frx_pkg::CH_W +: sbus_frx_pkg::CH_W],
                           ch == sbus_frx_pkg::NUM_CH - 1};
         return sbus_frx_pkg::NUM_CH;
      end
      if (b == START) begin
         frame_index = '0;
         return 0;
      end
      if (frame_index < sbus_frx_pkg::FRAME_LIMIT) begin
         if (b == END_MARK) begin
            end_armed = 1'b1;
         end else begin
            if (frame_index < sbus_frx_pkg::PAYLOAD_LEN)
               frame_store[frame_index] = b;
            frame_index = frame_index + 1'b1;
         end
         return 0;
      end
      decoded[0] = error_beat(S_OVF);
      return 1;
   endfunction

   // Offers one byte, waits for the beat to be taken, then books its results.
   task automatic send_beat(input logic [7:0] b);
      int n;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      n = decode_rx_byte(b);
      if (typed_row)
         channel_expect.push_back(error_beat(typed_status));
      else
         for (int i = 0; i < n; i++)
            channel_expect.push_back(decoded[i]);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (channel_expect.size() != 0) @(posedge clock);
   endtask

   // nonzero and not a start byte
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == START)
         b = 8'h10;
      return b;
   endfunction

   task automatic send_good_frame();
      send_beat(START);
      repeat (sbus_frx_pkg::PAYLOAD_BYTES) send_beat(payload_byte());
      send_beat(END_MARK);
      send_beat(END_MARK);
   endtask

   task automatic send_random(input int quota);
      int first;
      int kind;
      int k;
      first = bytes_sent;
      while (bytes_sent - first < quota) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            send_good_frame();
         end else if (kind < 70) begin
            // short or long payload, end marker, second marker maybe wrong
            send_beat(START);
            k = $urandom_range(0, 24);
            repeat (k) send_beat(payload_byte());
            send_beat(END_MARK);
            send_beat($urandom_range(0, 1) ? END_MARK : 8'($urandom_range(0, 255)));
         end else if (kind < 80) begin
            // index stays at 22 after a frame: run it up to the limit
            send_good_frame();
            repeat ($urandom_range(3, 5)) send_beat(payload_byte());
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)));
         end else if (kind < 88) begin
            // zero inside the payload is taken as an end marker
            send_beat(START);
            k = $urandom_range(1, 20);
            repeat (k) send_beat(payload_byte());
            send_beat(END_MARK);
            send_beat(8'($urandom_range(0, 255)));
            repeat (sbus_frx_pkg::PAYLOAD_BYTES - k) send_beat(payload_byte());
            send_beat(END_MARK);
            send_beat(END_MARK);
         end else begin
            repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
   endtask

   // result side: check each accepted beat, then drive stall for the next cycle
   always @(posedge clock) begin : rsp_side
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (channel_expect.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got status %0d ch %0d val %0d",
                     $time, rsp_status, rsp_channel_index, rsp_channel_value);
            mismatches++;
         end else begin
            want = channel_expect.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_channel_index !== want.chan)
               report_mismatch("channel_index", want.chan, rsp_channel_index);
            if (rsp_channel_value !== want.value)
               report_mismatch("channel_value", want.value, rsp_channel_value);
            if (rsp_last !== want.last)
               report_mismatch("last", want.last, rsp_last);
         end
      end
      if (hold_off_on && hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** sbus_frame_receiver: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < sbus_frx_pkg::PAYLOAD_BYTES; i++)
         frame_store[i] = 8'h00;
      directed_rows = '{
         {END_MARK, 1'b0, S_CH},       // arm right after reset
         {8'hFF, 1'b1, S_END},
         {START, 1'b0, S_CH},
         {8'hFF, 1'b0, S_CH}, {8'h01, 1'b0, S_CH},
         {8'h80, 1'b0, S_CH}, {8'h7F, 1'b0, S_CH},
         {8'hAA, 1'b0, S_CH}, {8'h55, 1'b0, S_CH},
         {8'hFE, 1'b0, S_CH}, {8'h10, 1'b0, S_CH},
         {8'hF0, 1'b0, S_CH}, {8'h0E, 1'b0, S_CH},
         {8'hC3, 1'b0, S_CH}, {8'h3C, 1'b0, S_CH},
         {8'h01, 1'b0, S_CH}, {8'hFF, 1'b0, S_CH},
         {8'h20, 1'b0, S_CH}, {8'h40, 1'b0, S_CH},
         {8'h08, 1'b0, S_CH}, {8'h04, 1'b0, S_CH},
         {8'h02, 1'b0, S_CH}, {8'hE7, 1'b0, S_CH},
         {8'h99, 1'b0, S_CH}, {8'h66, 1'b0, S_CH},
         {END_MARK, 1'b0, S_CH},
         {END_MARK, 1'b0, S_CH},       // full frame: sixteen channels
         {8'hA5, 1'b0, S_CH},          // index not cleared, 23..25
         {8'h5A, 1'b0, S_CH},
         {8'h81, 1'b0, S_CH},
         {END_MARK, 1'b1, S_OVF},      // zero at the limit overflows
         {8'hFE, 1'b1, S_OVF},
         {START, 1'b0, S_CH},
         {END_MARK, 1'b0, S_CH},
         {START, 1'b1, S_END},         // start byte while armed
         {END_MARK, 1'b0, S_CH},
         {END_MARK, 1'b0, S_CH}        // short frame: no result
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_stall_pct <= 86;
      for (int i = 0; i < N_DIRECTED; i++) begin
         typed_row    = directed_rows[i].typed;
         typed_status = directed_rows[i].status;
         send_beat(directed_rows[i].rx);
      end
      typed_row = 1'b0;
      wait_drained();

      send_random(BURST_ITEMS);
      wait_drained();

      send_idle_pct = 86;
      recv_stall_pct <= 8;
      send_random(BURST_ITEMS);
      wait_drained();

      // no idling; the receiver holds off during a frame's unpack while more
      // bytes follow, so the queue fills and the input stalls
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_off_on <= 1'b1;
      send_good_frame();
      send_random(BURST_ITEMS);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && channel_expect.size() == 0)
         $display("** sbus_frame_receiver: PASSED **");
      else
         $display("** sbus_frame_receiver: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/sbus_frx_pkg.sv
design/sbus_frx_queue.sv
design/sbus_frx_front.sv
design/sbus_frx_back.sv
design/sbus_frame_receiver.sv
test/testbench.sv
